// ===== hw/rtl/pcs_pkg.sv =====
package pcs_pkg;

  // Fixed field widths
  localparam int unsigned CntW     = 4;
  localparam int unsigned TaskIdxW = 3;

  // One input word
  typedef struct packed {
    logic                mode;
    logic [TaskIdxW-1:0] task_index;
    logic [CntW-1:0]     priority_value;
  } in_t;

  // One result word
  typedef struct packed {
    logic [TaskIdxW-1:0] running_task;
    logic                switched;
    logic [CntW-1:0]     slice_left;
    logic                refilled;
    logic                stuck;
  } out_t;

  // Broadcast command from the sequencer to the cell row
  typedef struct packed {
    logic            wr_prio;
    logic            dec;
    logic            refill;
    logic [CntW-1:0] prio;
  } cmd_t;

endpackage

// ===== hw/rtl/pcs_cell.sv =====
module pcs_cell #(
  parameter int unsigned SlotW = 3,
  parameter int unsigned Idx   = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pcs_pkg::cmd_t            cmd_i,
  input  logic [SlotW-1:0]         sel_i,
  input  logic [pcs_pkg::CntW-1:0] best_val_i,
  input  logic [SlotW-1:0]         best_idx_i,
  output logic [pcs_pkg::CntW-1:0] best_val_o,
  output logic [SlotW-1:0]         best_idx_o
);

  localparam logic [SlotW-1:0] MyIdx = SlotW'(Idx);

  logic [pcs_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [pcs_pkg::CntW-1:0] prio_q, prio_d;
  logic [pcs_pkg::CntW-1:0] best_val_q, best_val_d;
  logic [SlotW-1:0]         best_idx_q, best_idx_d;
  logic                     sel;

  assign sel = (sel_i == MyIdx);

  // Slot state: priority load, slice decrement, refill (idle slot never refills)
  always_comb begin
    cnt_d  = cnt_q;
    prio_d = prio_q;
    if (cmd_i.wr_prio && sel) begin
      prio_d = cmd_i.prio;
    end
    if (cmd_i.dec && sel) begin
      cnt_d = cnt_q - 1'b1;
    end else if (cmd_i.refill && (Idx != 0)) begin
      cnt_d = prio_q;
    end
  end

  // Max search stage: strictly greater wins, so the lower index keeps ties
  always_comb begin
    if (cnt_q > best_val_i) begin
      best_val_d = cnt_q;
      best_idx_d = MyIdx;
    end else begin
      best_val_d = best_val_i;
      best_idx_d = best_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      prio_q     <= '0;
      best_val_q <= '0;
      best_idx_q <= '0;
    end else begin
      cnt_q      <= cnt_d;
      prio_q     <= prio_d;
      best_val_q <= best_val_d;
      best_idx_q <= best_idx_d;
    end
  end

  assign best_val_o = best_val_q;
  assign best_idx_o = best_idx_q;

endmodule

// ===== hw/rtl/pcs_ctrl.sv =====
module pcs_ctrl #(
  parameter int unsigned TASK_COUNT     = 8,
  parameter int unsigned PRIORITY_LIMIT = 15,
  parameter int unsigned SlotW          = 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  pcs_pkg::in_t             in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output pcs_pkg::out_t            out_word_o,
  output pcs_pkg::cmd_t            cmd_o,
  output logic [SlotW-1:0]         sel_o,
  input  logic [pcs_pkg::CntW-1:0] scan_val_i,
  input  logic [SlotW-1:0]         scan_idx_i
);

  localparam int unsigned CntMax  = (1 << pcs_pkg::CntW) - 1;
  localparam int unsigned LimClip = (PRIORITY_LIMIT > CntMax) ? CntMax : PRIORITY_LIMIT;
  localparam logic [pcs_pkg::CntW-1:0] LimV = pcs_pkg::CntW'(LimClip);
  localparam int unsigned ScanW = $clog2(TASK_COUNT + 1);
  localparam logic [ScanW-1:0] ScanLast = ScanW'(TASK_COUNT);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [ScanW-1:0]         scan_cnt_q, scan_cnt_d;
  logic [SlotW-1:0]         run_q, run_d;
  logic [pcs_pkg::CntW-1:0] run_cnt_q, run_cnt_d;
  logic [SlotW-1:0]         before_q, before_d;
  logic                     refilled_q, refilled_d;
  logic                     stuck_q, stuck_d;
  logic                     out_valid_q, out_valid_d;
  pcs_pkg::out_t            out_q, out_d;

  logic                     accept;
  logic                     wr_ok;
  logic [pcs_pkg::CntW-1:0] prio_sat;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign wr_ok      = (in_word_i.task_index != '0) &&
                      (32'(in_word_i.task_index) < TASK_COUNT);
  assign prio_sat   = (in_word_i.priority_value > LimV) ? LimV : in_word_i.priority_value;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    scan_cnt_d  = scan_cnt_q;
    run_d       = run_q;
    run_cnt_d   = run_cnt_q;
    before_d    = before_q;
    refilled_d  = refilled_q;
    stuck_d     = stuck_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd_o       = '0;
    cmd_o.prio  = prio_sat;
    sel_o       = run_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          before_d   = run_q;
          refilled_d = 1'b0;
          stuck_d    = 1'b0;
          scan_cnt_d = '0;
          if (in_word_i.mode) begin
            // set priority
            sel_o         = SlotW'(in_word_i.task_index);
            cmd_o.wr_prio = wr_ok;
            state_d       = StDone;
          end else if ((run_q == '0) || (run_cnt_q == '0)) begin
            state_d = StScan;
          end else begin
            // use up one step of the running slice
            cmd_o.dec = 1'b1;
            run_cnt_d = run_cnt_q - 1'b1;
            state_d   = (run_cnt_q == pcs_pkg::CntW'(1)) ? StScan : StDone;
          end
        end
      end
      StScan: begin
        if (scan_cnt_q == ScanLast) begin
          if (scan_val_i != '0) begin
            run_d     = scan_idx_i;
            run_cnt_d = scan_val_i;
            state_d   = StDone;
          end else if (!refilled_q) begin
            // every counter empty: reload and search once more
            cmd_o.refill = 1'b1;
            refilled_d   = 1'b1;
            scan_cnt_d   = '0;
          end else begin
            stuck_d   = 1'b1;
            run_cnt_d = '0;
            state_d   = StDone;
          end
        end else begin
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
      end
      StDone: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_d.running_task = pcs_pkg::TaskIdxW'(run_q);
          out_d.switched     = (run_q != before_q);
          out_d.slice_left   = run_cnt_q;
          out_d.refilled     = refilled_q;
          out_d.stuck        = stuck_q;
          out_valid_d        = 1'b1;
          state_d            = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_cnt_q  <= '0;
      run_q       <= '0;
      run_cnt_q   <= '0;
      before_q    <= '0;
      refilled_q  <= 1'b0;
      stuck_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      run_q       <= run_d;
      run_cnt_q   <= run_cnt_d;
      before_q    <= before_d;
      refilled_q  <= refilled_d;
      stuck_q     <= stuck_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  a_stuck_after_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.stuck |-> out_word_o.refilled)
    else $error("stuck reported without a refill");

  a_stuck_empty_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.stuck |-> out_word_o.slice_left == '0)
    else $error("stuck with a nonzero slice");

  a_idle_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> (run_q != '0) || (run_cnt_q == '0))
    else $error("idle slot holds a slice");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_cnt_q <= ScanLast)
    else $error("scan counter overrun");

endmodule

// ===== hw/rtl/priority_counter_scheduler.sv =====
// Channel | Direction | Handshake                 | Word
// in      | input     | in_valid_i / in_stall_o   | in_word_i  (mode, task_index, priority_value)
// out     | output    | out_valid_o / out_stall_i | out_word_o (running_task, switched,
//         |           |                           |   slice_left, refilled, stuck)
//
// One word in at a time. Set-priority and a plain tick go from idle straight to the result;
// a tick that reschedules first runs the max search through the cell row, one cell per
// cycle, and runs it once more when the counters are refilled. Reset clears all counters,
// priorities and the running slot.
// A new word is taken while the previous result waits on out_stall_i; its result
// then holds until the output register frees.
module priority_counter_scheduler #(
  parameter int unsigned TASK_COUNT     = 8,
  parameter int unsigned PRIORITY_LIMIT = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pcs_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pcs_pkg::out_t out_word_o
);

  localparam int unsigned SlotW = $clog2(TASK_COUNT);

  pcs_pkg::cmd_t            cmd;
  logic [SlotW-1:0]         sel;
  logic [pcs_pkg::CntW-1:0] val_w [TASK_COUNT+1];
  logic [SlotW-1:0]         idx_w [TASK_COUNT+1];

  // Search enters the row with nothing found
  assign val_w[0] = '0;
  assign idx_w[0] = '0;

  // Row of slot cells
  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    pcs_cell #(
      .SlotW (SlotW),
      .Idx   (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .sel_i      (sel),
      .best_val_i (val_w[i]),
      .best_idx_i (idx_w[i]),
      .best_val_o (val_w[i+1]),
      .best_idx_o (idx_w[i+1])
    );
  end

  pcs_ctrl #(
    .TASK_COUNT     (TASK_COUNT),
    .PRIORITY_LIMIT (PRIORITY_LIMIT),
    .SlotW          (SlotW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cmd_o       (cmd),
    .sel_o       (sel),
    .scan_val_i  (val_w[TASK_COUNT]),
    .scan_idx_i  (idx_w[TASK_COUNT])
  );

endmodule

// ===== tb/sv/tb_priority_counter_scheduler.sv =====
module tb_priority_counter_scheduler;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned PRIO_MAX   = 15;
  localparam logic        MODE_TICK  = 1'b0;
  localparam logic        MODE_SET   = 1'b1;
  localparam int unsigned IDLE_SLOT  = 0;
  localparam int unsigned RAND_WORDS = 400;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned DRAIN_CYC  = 40;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  pcs_pkg::in_t  in_word_i;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  pcs_pkg::out_t out_word_o;

  priority_counter_scheduler #(
    .TASK_COUNT    (SLOTS),
    .PRIORITY_LIMIT(PRIO_MAX)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Scheduler mirror: slice counters, priorities, running slot
  logic [pcs_pkg::CntW-1:0]     slice_m [SLOTS];
  logic [pcs_pkg::CntW-1:0]     prio_m  [SLOTS];
  logic [pcs_pkg::TaskIdxW-1:0] run_slot;

  // Results still owed by the block, oldest first
  pcs_pkg::out_t sched_due_q[$];

  typedef struct {
    pcs_pkg::in_t  w;
    bit            typed;
    pcs_pkg::out_t res;
  } dir_row_t;
  dir_row_t dir_rows[$];

  int  mismatches = 0;
  int  cycle_cnt = 0;
  int  rx_wait = 0;
  bit  tx_quiet;
  bit  rx_quiet;
  int  n_tick, n_set, n_refill, n_stuck, n_switch;

  // Largest nonzero counter, lowest slot on ties; -1 when all are zero
  function automatic int busiest_slot();
    int best;
    int bestval;
    best    = -1;
    bestval = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (int'(slice_m[i]) > bestval) begin
        bestval = int'(slice_m[i]);
        best    = i;
      end
    end
    return best;
  endfunction

  // Advance the mirror by one word and return the result it owes
  function automatic pcs_pkg::out_t sched_step(pcs_pkg::in_t w);
    pcs_pkg::out_t                r;
    logic [pcs_pkg::TaskIdxW-1:0] prev;
    int                           pv;
    int                           pick;
    bit                           resched;
    r       = '0;
    prev    = run_slot;
    resched = 1'b0;
    if (w.mode == MODE_SET) begin
      if (w.task_index != IDLE_SLOT && int'(w.task_index) < SLOTS) begin
        pv = int'(w.priority_value);
        if (pv > PRIO_MAX) pv = PRIO_MAX;
        prio_m[w.task_index] = pv[pcs_pkg::CntW-1:0];
      end
    end else begin
      if (run_slot == IDLE_SLOT || slice_m[run_slot] == '0) begin
        resched = 1'b1;
      end else begin
        slice_m[run_slot] = slice_m[run_slot] - 1'b1;
        resched = (slice_m[run_slot] == '0);
      end
      if (resched) begin
        pick = busiest_slot();
        if (pick < 0) begin
          // all counters spent: reload from priorities, idle slot excluded
          for (int i = 1; i < SLOTS; i++) slice_m[i] = prio_m[i];
          r.refilled = 1'b1;
          pick = busiest_slot();
        end
        if (pick < 0) r.stuck = 1'b1;
        else run_slot = pick[pcs_pkg::TaskIdxW-1:0];
      end
    end
    r.running_task = run_slot;
    r.switched     = (run_slot != prev);
    r.slice_left   = slice_m[run_slot];
    return r;
  endfunction

  function automatic pcs_pkg::in_t mk_word(logic mode, int idx, int pv);
    pcs_pkg::in_t w;
    w.mode           = mode;
    w.task_index     = idx[pcs_pkg::TaskIdxW-1:0];
    w.priority_value = pv[pcs_pkg::CntW-1:0];
    return w;
  endfunction

  task automatic add_row(logic mode, int idx, int pv, bit typed, pcs_pkg::out_t res);
    dir_row_t row;
    row.w     = mk_word(mode, idx, pv);
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // Present one word, wait for the handshake, then idle for a drawn gap
  task automatic send_word(pcs_pkg::in_t w, bit typed, pcs_pkg::out_t res);
    pcs_pkg::out_t pred;
    int            gap;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    pred = sched_step(w);
    sched_due_q.push_back(typed ? res : pred);
    if (w.mode == MODE_TICK) n_tick++;
    else n_set++;
    if (pred.refilled) n_refill++;
    if (pred.stuck) n_stuck++;
    if (pred.switched) n_switch++;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result checker and output stall generator
  always @(posedge clk_i) begin
    pcs_pkg::out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sched_due_q.size() == 0) begin
        $error("unexpected result word %h", out_word_o);
        mismatches++;
      end else begin
        exp_r = sched_due_q.pop_front();
        if (out_word_o.running_task !== exp_r.running_task) begin
          $error("running_task: expected %0d, got %0d",
                 exp_r.running_task, out_word_o.running_task);
          mismatches++;
        end
        if (out_word_o.switched !== exp_r.switched) begin
          $error("switched: expected %0d, got %0d", exp_r.switched, out_word_o.switched);
          mismatches++;
        end
        if (out_word_o.slice_left !== exp_r.slice_left) begin
          $error("slice_left: expected %0d, got %0d",
                 exp_r.slice_left, out_word_o.slice_left);
          mismatches++;
        end
        if (out_word_o.refilled !== exp_r.refilled) begin
          $error("refilled: expected %0d, got %0d", exp_r.refilled, out_word_o.refilled);
          mismatches++;
        end
        if (out_word_o.stuck !== exp_r.stuck) begin
          $error("stuck: expected %0d, got %0d", exp_r.stuck, out_word_o.stuck);
          mismatches++;
        end
      end
      rx_wait = rx_quiet ? 0 : $urandom_range(0, 16);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall_i <= (rx_wait > 0);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    pcs_pkg::in_t w;
    int  sent;
    int  phase;
    int  idx;
    int  pv;
    bit  held;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    held        = 1'b0;
    n_tick = 0; n_set = 0; n_refill = 0; n_stuck = 0; n_switch = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slice_m[i] = '0;
      prio_m[i]  = '0;
    end
    run_slot = IDLE_SLOT;

    // Directed words
    // all priorities zero out of reset: tick flags stuck
    add_row(MODE_TICK, 0, 0, 1, pcs_pkg::out_t'{3'd0, 1'b0, 4'd0, 1'b1, 1'b1});
    // writes to the idle slot are dropped
    add_row(MODE_SET, 0, 15, 1, pcs_pkg::out_t'{3'd0, 1'b0, 4'd0, 1'b0, 1'b0});
    add_row(MODE_TICK, 0, 0, 1, pcs_pkg::out_t'{3'd0, 1'b0, 4'd0, 1'b1, 1'b1});
    add_row(MODE_SET, 3, 1, 1, pcs_pkg::out_t'{3'd0, 1'b0, 4'd0, 1'b0, 1'b0});
    // idle running: refill, slot 3 picked
    add_row(MODE_TICK, 0, 0, 1, pcs_pkg::out_t'{3'd3, 1'b1, 4'd1, 1'b1, 1'b0});
    // slot 3 runs out and is the only candidate again: no switch
    add_row(MODE_TICK, 0, 0, 1, pcs_pkg::out_t'{3'd3, 1'b0, 4'd1, 1'b1, 1'b0});
    add_row(MODE_SET, 3, 0, 1, pcs_pkg::out_t'{3'd3, 1'b0, 4'd1, 1'b0, 1'b0});
    // counter hits zero with every priority zero: stuck, slot kept
    add_row(MODE_TICK, 0, 0, 1, pcs_pkg::out_t'{3'd3, 1'b0, 4'd0, 1'b1, 1'b1});
    add_row(MODE_TICK, 0, 0, 1, pcs_pkg::out_t'{3'd3, 1'b0, 4'd0, 1'b1, 1'b1});
    add_row(MODE_SET, 7, 15, 1, pcs_pkg::out_t'{3'd3, 1'b0, 4'd0, 1'b0, 1'b0});
    add_row(MODE_SET, 1, 15, 1, pcs_pkg::out_t'{3'd3, 1'b0, 4'd0, 1'b0, 1'b0});
    add_row(MODE_SET, 2, 8, 0, '0);
    // tie at 15 between slots 1 and 7: lowest slot wins
    add_row(MODE_TICK, 0, 0, 1, pcs_pkg::out_t'{3'd1, 1'b1, 4'd15, 1'b1, 1'b0});
    add_row(MODE_TICK, 0, 0, 1, pcs_pkg::out_t'{3'd1, 1'b0, 4'd14, 1'b0, 1'b0});
    add_row(MODE_SET, 6, 10, 0, '0);
    add_row(MODE_SET, 4, 5, 0, '0);
    add_row(MODE_SET, 5, 7, 0, '0);
    add_row(MODE_SET, 1, 1, 0, '0);
    add_row(MODE_TICK, 1, 15, 0, '0);
    add_row(MODE_TICK, 7, 15, 0, '0);
    add_row(MODE_TICK, 0, 0, 0, '0);
    add_row(MODE_SET, 6, 0, 0, '0);
    add_row(MODE_TICK, 0, 0, 0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

    // Random words; idling style changes every 60 words
    sent = 0;
    while (sent < RAND_WORDS) begin
      phase    = sent / 60;
      tx_quiet = (phase % 4 == 1) || (phase % 4 == 3);
      rx_quiet = (phase % 4 == 2) || (phase % 4 == 3);
      if (!held && sent >= RAND_WORDS / 2) begin
        // hold off until the block has handed back everything
        held       = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sched_due_q.size() != 0);
      end
      if ($urandom_range(0, 49) == 0) begin
        // zero every priority so the counters run dry and the block sticks
        for (int s = 1; s < SLOTS; s++) begin
          send_word(mk_word(MODE_SET, s, 0), 1'b0, '0);
          sent++;
        end
      end else if ($urandom_range(0, 9) < 3) begin
        idx = $urandom_range(0, SLOTS - 1);
        pv  = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 3);
        send_word(mk_word(MODE_SET, idx, pv), 1'b0, '0);
        if (idx != IDLE_SLOT) sent++;
      end else begin
        // unused fields carry noise on ticks
        w = mk_word(MODE_TICK, $urandom_range(0, 7), $urandom_range(0, 15));
        send_word(w, 1'b0, '0);
        sent++;
      end
    end

    // Drain
    in_valid_i <= 1'b0;
    rx_quiet   = 1'b0;
    while (sched_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Covered %0d ticks and %0d priority writes.", n_tick, n_set);
    $display("Saw %0d refills, %0d stuck reschedules, %0d task switches; %0d mismatches.",
             n_refill, n_stuck, n_switch, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
